// ===== sv/rmth_pkg.sv =====
package rmth_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS = 11;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// heap sequencer command
	typedef enum logic [1:0] {
		HOP_PUSH = 2'd0,
		HOP_POP  = 2'd1
	} heap_op_t;

	typedef struct packed {
		logic     start;
		heap_op_t op;
		logic     sel_upper;
	} heap_cmd_t;

endpackage

// ===== sv/rmth_heap.sv =====
// one heap in a single-port memory; push sifts up, pop sifts down,
// one memory access per cycle
module rmth_heap #(
	parameter int DEPTH = 512,
	parameter int SAMPLE_BITS = 16,
	parameter bit IS_MAX = 1'b1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          start,
	input  rmth_pkg::heap_op_t            op,
	input  logic signed [SAMPLE_BITS-1:0] push_value,
	output logic                          busy,
	output logic signed [SAMPLE_BITS-1:0] top,
	output logic signed [SAMPLE_BITS-1:0] popped,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import rmth_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_UPRD   = 10'b0000000010,
		S_UPCMP  = 10'b0000000100,
		S_POPRD  = 10'b0000001000,
		S_POPLD  = 10'b0000010000,
		S_DNRDL  = 10'b0000100000,
		S_DNRDR  = 10'b0001000000,
		S_DNLAT  = 10'b0010000000,
		S_DNCMP  = 10'b0100000000,
		S_WRBK   = 10'b1000000000
	} hst_t;

	hst_t state_q;
	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q, cur_q, lv_q, rv_q, top_q, pop_q;
	logic [AW-1:0] idx_q, addr;
	logic [CW-1:0] cnt_q;
	logic          we, l_ok_q, r_ok_q;
	logic signed [SAMPLE_BITS-1:0] wd;
	logic [AW:0]   lch, rch;
	logic [AW-1:0] par;
	logic          up_move, dn_l, dn_r;

	function automatic logic above(input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b);
		return IS_MAX ? (a > b) : (a < b);
	endfunction

	assign lch = {idx_q, 1'b1};
	assign rch = {idx_q, 1'b0} + (AW+1)'(2);
	assign par = (idx_q - AW'(1)) >> 1;

	// the moving value goes up past the parent, or the better child comes up
	assign up_move = above(cur_q, rd_q);
	assign dn_l = l_ok_q && above(lv_q, cur_q) && !(r_ok_q && above(rv_q, lv_q));
	assign dn_r = r_ok_q && above(rv_q, cur_q) &&
		(!l_ok_q || above(rv_q, lv_q) || !above(lv_q, cur_q));

	// address and write mux for the single memory port
	always_comb begin
		we = 1'b0;
		wd = cur_q;
		addr = idx_q;
		case (state_q)
			S_UPRD: addr = par;
			S_UPCMP: begin
				we = up_move;
				wd = rd_q;
			end
			S_POPRD: addr = cnt_q[AW-1:0];
			S_DNRDL: addr = lch[AW-1:0];
			S_DNRDR: addr = rch[AW-1:0];
			S_DNCMP: begin
				we = dn_l || dn_r;
				wd = dn_l ? lv_q : rv_q;
			end
			S_WRBK: we = 1'b1;
			default: addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			lv_q <= '0;
			rv_q <= '0;
			l_ok_q <= 1'b0;
			r_ok_q <= 1'b0;
			top_q <= '0;
			pop_q <= '0;
		end else if (clear) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					if (op == HOP_PUSH) begin
						idx_q <= cnt_q[AW-1:0];
						cur_q <= push_value;
						cnt_q <= cnt_q + CW'(1);
						state_q <= (cnt_q == '0) ? S_WRBK : S_UPRD;
					end else begin
						pop_q <= top_q;
						cnt_q <= cnt_q - CW'(1);
						idx_q <= '0;
						state_q <= S_POPRD;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (up_move) begin
						// parent moves down into the hole
						idx_q <= par;
						state_q <= (par == '0) ? S_WRBK : S_UPRD;
					end else
						state_q <= S_WRBK;
				end
				S_POPRD: state_q <= S_POPLD;
				S_POPLD: begin
					cur_q <= rd_q;
					state_q <= (cnt_q == '0) ? S_IDLE : S_DNRDL;
				end
				S_DNRDL: state_q <= S_DNRDR;
				S_DNRDR: begin
					lv_q <= rd_q;
					state_q <= S_DNLAT;
				end
				S_DNLAT: begin
					rv_q <= rd_q;
					l_ok_q <= lch < (AW+1)'(cnt_q);
					r_ok_q <= rch < (AW+1)'(cnt_q);
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (dn_l) begin
						if (idx_q == '0)
							top_q <= lv_q;
						idx_q <= lch[AW-1:0];
						state_q <= S_DNRDL;
					end else if (dn_r) begin
						if (idx_q == '0)
							top_q <= rv_q;
						idx_q <= rch[AW-1:0];
						state_q <= S_DNRDL;
					end else
						state_q <= S_WRBK;
				end
				S_WRBK: begin
					if (idx_q == '0)
						top_q <= cur_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign top = top_q;
	assign popped = pop_q;
	assign count = cnt_q;

endmodule

// ===== sv/running_median_two_heaps.sv =====
// running median of a signed sample stream, kept in two heaps
// input channel: valid/ready carrying mode and sample; mode clear empties
// both heaps, mode insert adds the sample (dropped with overflow when full)
// output channel: valid/ready carrying median_x2 (twice the median),
// median_valid, sample_count and overflow, one word per input word
// an insert runs one push, or a pop and two pushes, on the heap sequencers;
// a push moves up the heap level by level and a pop moves down level by level,
// between the accept, decode and output load steps; a clear or a dropped
// sample runs no heap operation, only decode, wait and output load;
// a new input word is accepted only once the last result is loaded
// the result word becomes valid in the same cycle that ready rises again
// a stalled receiver holds the result word stable in the output register;
// the next word is still accepted and worked on, and ready stays low once
// its result is done and the output register is still full
// reset empties both heaps and the output register, no clearing pass needed
module running_median_two_heaps #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS:0]   median_x2,
	output logic                          median_valid,
	output logic [rmth_pkg::COUNT_BITS-1:0] sample_count,
	output logic                          overflow
);
	import rmth_pkg::*;

	localparam int LD = (CAPACITY + 1) / 2;
	localparam int UD = CAPACITY / 2;
	localparam int LCW = $clog2(LD+1);
	localparam int UCW = $clog2(UD+1);

	typedef enum logic [6:0] {
		T_IDLE = 7'b0000001,
		T_DEC  = 7'b0000010,
		T_OP1  = 7'b0000100,
		T_OP2  = 7'b0001000,
		T_OP3  = 7'b0010000,
		T_WAIT = 7'b0100000,
		T_OUT  = 7'b1000000
	} tst_t;

	typedef enum logic [1:0] {
		PLAN_LOWER = 2'd0,
		PLAN_UPPER = 2'd1,
		PLAN_UP2LO = 2'd2,
		PLAN_LO2UP = 2'd3
	} plan_t;

	tst_t state_q, ret_q;
	logic mode_q, ovf_q, clr, out_load;
	logic signed [SAMPLE_BITS-1:0] x_q;
	plan_t plan_q;
	heap_cmd_t cmd;
	logic l_busy, u_busy;
	logic signed [SAMPLE_BITS-1:0] l_top, u_top, l_pop, u_pop, l_pv, u_pv;
	logic [LCW-1:0] l_cnt;
	logic [UCW-1:0] u_cnt;
	logic [COUNT_BITS-1:0] total;

	assign total = COUNT_BITS'(l_cnt) + COUNT_BITS'(u_cnt);
	assign clr = (state_q == T_DEC) && mode_q == MODE_CLEAR;
	assign out_load = (state_q == T_OUT) && (!out_valid || out_ready);

	always_comb begin
		cmd = '{start: 1'b0, op: HOP_PUSH, sel_upper: 1'b0};
		l_pv = x_q;
		u_pv = x_q;
		case (state_q)
			T_OP1: begin
				cmd.start = 1'b1;
				case (plan_q)
					PLAN_LOWER: cmd.sel_upper = 1'b0;
					PLAN_UPPER: cmd.sel_upper = 1'b1;
					PLAN_UP2LO: begin cmd.op = HOP_POP; cmd.sel_upper = 1'b1; end
					default: begin cmd.op = HOP_POP; cmd.sel_upper = 1'b0; end
				endcase
			end
			T_OP2: begin
				cmd.start = 1'b1;
				cmd.sel_upper = (plan_q == PLAN_LO2UP);
				l_pv = u_pop;
				u_pv = l_pop;
			end
			T_OP3: begin
				cmd.start = 1'b1;
				cmd.sel_upper = (plan_q == PLAN_UP2LO);
			end
			default: cmd.start = 1'b0;
		endcase
	end

	rmth_heap #(.DEPTH(LD), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b1)) u_lower (
		.clk(clk), .arst_n(arst_n), .clear(clr),
		.start(cmd.start && !cmd.sel_upper), .op(cmd.op), .push_value(l_pv),
		.busy(l_busy), .top(l_top), .popped(l_pop), .count(l_cnt)
	);
	rmth_heap #(.DEPTH(UD), .SAMPLE_BITS(SAMPLE_BITS), .IS_MAX(1'b0)) u_upper (
		.clk(clk), .arst_n(arst_n), .clear(clr),
		.start(cmd.start && cmd.sel_upper), .op(cmd.op), .push_value(u_pv),
		.busy(u_busy), .top(u_top), .popped(u_pop), .count(u_cnt)
	);

	assign in_ready = (state_q == T_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			ret_q <= T_IDLE;
			mode_q <= MODE_INSERT;
			x_q <= '0;
			ovf_q <= 1'b0;
			plan_q <= PLAN_LOWER;
			overflow <= 1'b0;
			sample_count <= '0;
			median_valid <= 1'b0;
			median_x2 <= '0;
		end else begin
			case (state_q)
				T_IDLE: if (in_valid) begin
					mode_q <= mode;
					x_q <= sample;
					state_q <= T_DEC;
				end
				T_DEC: begin
					ovf_q <= 1'b0;
					if (mode_q == MODE_CLEAR)
						state_q <= T_WAIT;
					else if (total >= COUNT_BITS'(CAPACITY)) begin
						ovf_q <= 1'b1;
						state_q <= T_WAIT;
					end else begin
						state_q <= T_OP1;
						if (l_cnt == '0)
							plan_q <= PLAN_LOWER;
						else if (LCW'(u_cnt) == l_cnt)
							plan_q <= (u_cnt != '0 && x_q > u_top) ? PLAN_UP2LO : PLAN_LOWER;
						else
							plan_q <= (x_q >= l_top) ? PLAN_UPPER : PLAN_LO2UP;
					end
					ret_q <= T_OUT;
				end
				T_OP1: begin
					state_q <= T_WAIT;
					ret_q <= (plan_q inside {PLAN_UP2LO, PLAN_LO2UP}) ? T_OP2 : T_OUT;
				end
				T_OP2: begin
					state_q <= T_WAIT;
					ret_q <= T_OP3;
				end
				T_OP3: begin
					state_q <= T_WAIT;
					ret_q <= T_OUT;
				end
				T_WAIT: if (!l_busy && !u_busy)
					state_q <= ret_q;
				T_OUT: if (out_load) begin
					overflow <= ovf_q;
					sample_count <= total;
					median_valid <= l_cnt != '0;
					if (l_cnt == '0)
						median_x2 <= '0;
					else if (LCW'(u_cnt) == l_cnt)
						median_x2 <= (SAMPLE_BITS+1)'(l_top) + (SAMPLE_BITS+1)'(u_top);
					else
						median_x2 <= {l_top, 1'b0};
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// output register: filled from the sequencer, emptied by the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

endmodule
